// File: rtl/sprite_xor_draw_with_collision_unit_macros.svh
// ----------------------------------------------------------------------------
// sprite xor draw unit assertion macros
// shared property wrappers for the checker, clocked on clock, off in reset
// ----------------------------------------------------------------------------
`ifndef SPRITE_XOR_DRAW_WITH_COLLISION_UNIT_MACROS_SVH
`define SPRITE_XOR_DRAW_WITH_COLLISION_UNIT_MACROS_SVH

// same-cycle implication
`define SXD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("sxd assertion failed");

// next-cycle implication
`define SXD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("sxd assertion failed");

`endif

// File: rtl/sxd_pkg.sv
// ----------------------------------------------------------------------------
// sxd_pkg
// shared types, constants and the sprite row placement function
// ----------------------------------------------------------------------------
`default_nettype none

package sxd_pkg;

   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int SPRITE_WIDTH  = 8;
   localparam int COL_BITS      = $clog2(SCREEN_WIDTH);
   localparam int ROW_BITS      = $clog2(SCREEN_HEIGHT);

   typedef enum logic [1:0] {
      OP_CLEAR = 2'd0,
      OP_DRAW  = 2'd1,
      OP_READ  = 2'd2,
      OP_SET   = 2'd3
   } opcode_type;

   typedef struct packed {
      logic                    en;
      logic                    clr;
      logic [ROW_BITS-1:0]     addr;
      logic [SCREEN_WIDTH-1:0] data;
   } mem_wr_type;

   // sprite byte at the left edge, rotated right by the column
   function automatic logic [SCREEN_WIDTH-1:0] sprite_mask(
      input logic [SPRITE_WIDTH-1:0] bits,
      input logic [COL_BITS-1:0]     col
   );
      logic [SCREEN_WIDTH-1:0]   m;
      logic [2*SCREEN_WIDTH-1:0] dbl;
      m   = {bits, {(SCREEN_WIDTH-SPRITE_WIDTH){1'b0}}};
      dbl = {m, m} >> col;
      return dbl[SCREEN_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// File: rtl/sxd_frame_mem.sv
// ----------------------------------------------------------------------------
// sxd_frame_mem
// frame buffer rows, one write and one registered read per cycle,
// per-row valid bits so a clear takes effect at once
// ----------------------------------------------------------------------------
`default_nettype none

module sxd_frame_mem (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [sxd_pkg::ROW_BITS-1:0]     rd_addr,
   output logic      [sxd_pkg::SCREEN_WIDTH-1:0] rd_data,
   input  wire sxd_pkg::mem_wr_type              wr
);

   logic [sxd_pkg::SCREEN_WIDTH-1:0]  mem [sxd_pkg::SCREEN_HEIGHT];
   logic [sxd_pkg::SCREEN_WIDTH-1:0]  rd_q_ff;
   logic [sxd_pkg::SCREEN_HEIGHT-1:0] row_valid_ff;
   logic                              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_q_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_valid_ff  <= 1'b0;
      end else begin
         if (wr.clr) begin
            row_valid_ff <= '0;
         end else if (wr.en) begin
            row_valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= row_valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

// File: rtl/sprite_xor_draw_with_collision_unit.sv
// ----------------------------------------------------------------------------
// sprite_xor_draw_with_collision_unit
// 64x32 monochrome frame buffer with xor sprite drawing and collision flag
// ----------------------------------------------------------------------------
// usage:
//   a command transfers when start is high and busy is low; req_opcode picks
//   clear, draw one sprite row, read one buffer row or set the redraw flag.
//   every command gives exactly one result, shown for one cycle with
//   rsp_valid high; the receiver cannot stall, so results are never held.
// pipeline and throughput:
//   the result passes the registered frame row read and then the xor and
//   result register before it appears.
//   one command per cycle is sustained; a row written by one command is
//   forwarded to a command that reads the same row in the next cycle.
// reset:
//   synchronous reset empties the frame buffer through its row valid bits,
//   clears the collision accumulator and the redraw flag, drops any command
//   in flight; busy is high during reset and in the cycle after it.
// ----------------------------------------------------------------------------
`default_nettype none

module sprite_xor_draw_with_collision_unit (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [1:0]                       req_opcode,
   input  wire logic [7:0]                       req_pos_x,
   input  wire logic [7:0]                       req_pos_y,
   input  wire logic [3:0]                       req_row_offset,
   input  wire logic [7:0]                       req_sprite_bits,
   input  wire logic                             req_last_row,
   input  wire logic [4:0]                       req_read_row,
   input  wire logic                             req_flag_value,
   output logic                                  rsp_valid,
   output logic                                  rsp_collision,
   output logic      [sxd_pkg::SCREEN_WIDTH-1:0] rsp_row_pixels,
   output logic                                  rsp_redraw_pending
);

   logic                             busy_ff;
   logic                             accept;
   sxd_pkg::opcode_type              op_in;
   logic [sxd_pkg::ROW_BITS-1:0]     addr_in;
   logic [sxd_pkg::SCREEN_WIDTH-1:0] mask_in;

   logic                             item_valid_ff;
   sxd_pkg::opcode_type              item_op_ff;
   logic [sxd_pkg::ROW_BITS-1:0]     item_addr_ff;
   logic [sxd_pkg::SCREEN_WIDTH-1:0] item_mask_ff;
   logic                             item_last_ff;
   logic                             item_flag_ff;

   logic                             fwd_hit_ff;
   logic                             fwd_hit_in;
   logic [sxd_pkg::SCREEN_WIDTH-1:0] fwd_data_ff;
   logic [sxd_pkg::SCREEN_WIDTH-1:0] fwd_data_in;

   logic [sxd_pkg::SCREEN_WIDTH-1:0] mem_rd_data;
   sxd_pkg::mem_wr_type              mem_wr;

   logic [sxd_pkg::SCREEN_WIDTH-1:0] cur_row;
   logic [sxd_pkg::SCREEN_WIDTH-1:0] new_row;
   logic                             hit;

   logic                             coll_acc_ff;
   logic                             coll_acc_in;
   logic                             redraw_ff;
   logic                             redraw_in;

   logic                             rsp_valid_ff;
   logic                             rsp_collision_ff;
   logic                             rsp_collision_in;
   logic [sxd_pkg::SCREEN_WIDTH-1:0] rsp_row_pixels_ff;
   logic [sxd_pkg::SCREEN_WIDTH-1:0] rsp_row_pixels_in;
   logic                             rsp_redraw_pending_ff;

   assign busy   = reset | busy_ff;
   assign accept = start & ~busy;

   // command decode at transfer
   assign op_in   = sxd_pkg::opcode_type'(req_opcode);
   assign mask_in = sxd_pkg::sprite_mask(req_sprite_bits,
                                         req_pos_x[sxd_pkg::COL_BITS-1:0]);
   always_comb begin
      if (op_in == sxd_pkg::OP_READ) begin
         addr_in = req_read_row;
      end else begin
         addr_in = req_pos_y[sxd_pkg::ROW_BITS-1:0]
                 + {{(sxd_pkg::ROW_BITS-4){1'b0}}, req_row_offset};
      end
   end

   sxd_frame_mem u_frame_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (addr_in),
      .rd_data (mem_rd_data),
      .wr      (mem_wr)
   );

   // row update for the command in flight
   assign cur_row = fwd_hit_ff ? fwd_data_ff : mem_rd_data;
   assign new_row = cur_row ^ item_mask_ff;
   assign hit     = |(cur_row & item_mask_ff);

   always_comb begin
      mem_wr.en   = item_valid_ff && (item_op_ff == sxd_pkg::OP_DRAW);
      mem_wr.clr  = item_valid_ff && (item_op_ff == sxd_pkg::OP_CLEAR);
      mem_wr.addr = item_addr_ff;
      mem_wr.data = new_row;
   end

   // forward a write or clear to the row read that happens alongside it
   always_comb begin
      fwd_hit_in  = mem_wr.clr || (mem_wr.en && (item_addr_ff == addr_in));
      fwd_data_in = mem_wr.clr ? '0 : new_row;
   end

   always_comb begin
      coll_acc_in       = coll_acc_ff;
      redraw_in         = redraw_ff;
      rsp_collision_in  = coll_acc_ff;
      rsp_row_pixels_in = '0;
      unique case (item_op_ff)
         sxd_pkg::OP_CLEAR: begin
            redraw_in = 1'b1;
         end
         sxd_pkg::OP_DRAW: begin
            redraw_in        = 1'b1;
            rsp_collision_in = coll_acc_ff | hit;
            coll_acc_in      = item_last_ff ? 1'b0 : (coll_acc_ff | hit);
         end
         sxd_pkg::OP_READ: begin
            rsp_row_pixels_in = cur_row;
         end
         sxd_pkg::OP_SET: begin
            redraw_in = item_flag_ff;
         end
         default: begin
            redraw_in = redraw_ff;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         item_valid_ff <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         coll_acc_ff   <= 1'b0;
         redraw_ff     <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         busy_ff       <= 1'b0;
         item_valid_ff <= accept;
         fwd_hit_ff    <= fwd_hit_in;
         rsp_valid_ff  <= item_valid_ff;
         if (item_valid_ff) begin
            coll_acc_ff <= coll_acc_in;
            redraw_ff   <= redraw_in;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      fwd_data_ff <= fwd_data_in;
      if (accept) begin
         item_op_ff   <= op_in;
         item_addr_ff <= addr_in;
         item_mask_ff <= mask_in;
         item_last_ff <= req_last_row;
         item_flag_ff <= req_flag_value;
      end
      if (item_valid_ff) begin
         rsp_collision_ff      <= rsp_collision_in;
         rsp_row_pixels_ff     <= rsp_row_pixels_in;
         rsp_redraw_pending_ff <= redraw_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_collision      = rsp_collision_ff;
   assign rsp_row_pixels     = rsp_row_pixels_ff;
   assign rsp_redraw_pending = rsp_redraw_pending_ff;

endmodule

`default_nettype wire

// File: rtl/sxd_checker.sv
// ----------------------------------------------------------------------------
// sxd_checker
// port-level timing and result checks, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sprite_xor_draw_with_collision_unit_macros.svh"

module sxd_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             start,
   input wire logic                             busy,
   input wire logic [1:0]                       req_opcode,
   input wire logic                             req_flag_value,
   input wire logic                             rsp_valid,
   input wire logic [sxd_pkg::SCREEN_WIDTH-1:0] rsp_row_pixels,
   input wire logic                             rsp_redraw_pending
);

   logic xfer;
   logic xfer_not_read;
   logic xfer_draws;
   logic xfer_set;

   assign xfer          = start && !busy;
   assign xfer_not_read = xfer && (req_opcode != sxd_pkg::OP_READ);
   assign xfer_draws    = xfer && ((req_opcode == sxd_pkg::OP_CLEAR) ||
                                   (req_opcode == sxd_pkg::OP_DRAW));
   assign xfer_set      = xfer && (req_opcode == sxd_pkg::OP_SET);

   // every transfer gives a result, and no result appears without a transfer
   `SXD_ASSERT_NEXT(a_result_follows, xfer, ##1 rsp_valid)
   `SXD_ASSERT_NOW(a_no_spurious_result, rsp_valid, $past(xfer, 2))
   // non-read results carry no pixels
   `SXD_ASSERT_NOW(a_pixels_only_on_read, rsp_valid && $past(xfer_not_read, 2),
                   rsp_row_pixels == '0)
   // clear and draw raise the redraw flag, set writes it
   `SXD_ASSERT_NOW(a_redraw_raised, rsp_valid && $past(xfer_draws, 2),
                   rsp_redraw_pending)
   `SXD_ASSERT_NOW(a_redraw_set, rsp_valid && $past(xfer_set, 2),
                   rsp_redraw_pending == $past(req_flag_value, 2))

endmodule

bind sprite_xor_draw_with_collision_unit sxd_checker u_sxd_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_opcode         (req_opcode),
   .req_flag_value     (req_flag_value),
   .rsp_valid          (rsp_valid),
   .rsp_row_pixels     (rsp_row_pixels),
   .rsp_redraw_pending (rsp_redraw_pending)
);

`default_nettype wire
